### src/pedb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedb_pkg
// Shared constants, register indexes and event codes for the pulsed echo
// presence debouncer.
// ----------------------------------------------------------------------------
package pedb_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int REG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int MODE_BITS      = 2;
  localparam int LOAD_BITS      = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

  localparam int TICKS_PER_SECOND   = 1000;
  localparam int PINGS_PER_SECOND   = 10;
  localparam int PINGS_PER_DEBOUNCE = 3;

  localparam logic [REG_BITS-1:0] PING_INTERVAL_RESET =
    REG_BITS'(TICKS_PER_SECOND / PINGS_PER_SECOND);
  localparam logic [REG_BITS-1:0] DEBOUNCE_RESET =
    REG_BITS'(PINGS_PER_DEBOUNCE * (TICKS_PER_SECOND / PINGS_PER_SECOND));

  localparam logic [LOAD_BITS-1:0] COUNT_MAX =
    LOAD_BITS'((64'd1 << COUNT_BITS) - 64'd1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_PING_INTERVAL = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE      = CFG_INDEX_BITS'(1);

  localparam logic [MODE_BITS-1:0] MODE_TICK      = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_ECHO      = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_BURST_END = MODE_BITS'(2);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [REG_BITS-1:0]   reg_t;

  // saturate a register value into the countdown width
  function automatic count_t load_count(input reg_t v);
    logic [LOAD_BITS-1:0] ext;
    ext = LOAD_BITS'(v);
    if (ext > COUNT_MAX) begin
      return '1;
    end
    return ext[COUNT_BITS-1:0];
  endfunction

endpackage

### src/pulsed_echo_presence_debouncer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulsed_echo_presence_debouncer
// Paces emitter pings, latches echoes, debounces the raw detection and
// reports each stable change once. One result beat per input beat.
// ----------------------------------------------------------------------------
// Result register: the result of an accepted input beat is valid from the next cycle.
// Throughput: 1 beat per cycle; the input is taken whenever the result
//   register is empty or being drained in the same cycle.
// Reset (rst, synchronous): registers back to 100 / 300 ticks, all flags and
//   countdowns cleared, so the first beat starts a ping. No clearing pass.
module pulsed_echo_presence_debouncer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pedb_pkg::MODE_BITS-1:0]     mode,
  input  logic                               echo_level,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ping_start,
  output logic                               ping_active,
  output logic                               event_valid,
  output logic                               event_present,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pedb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pedb_pkg::REG_BITS-1:0]      cfg_data
);
  import pedb_pkg::*;

  reg_t   ping_interval_ticks;
  reg_t   debounce_ticks;
  logic   pinging, pinging_next;
  logic   echo_latch, echo_latch_next;
  logic   raw_present, raw_present_next;
  logic   last_raw_present, last_raw_present_next;
  logic   debounce_armed, debounce_armed_next;
  count_t debounce_left, debounce_left_next;
  count_t ping_wait_left, ping_wait_left_next;
  logic   start_next, valid_next, present_next;
  logic   in_fire;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    pinging_next          = pinging;
    echo_latch_next       = echo_latch;
    raw_present_next      = raw_present;
    last_raw_present_next = last_raw_present;
    debounce_armed_next   = debounce_armed;
    debounce_left_next    = debounce_left;
    ping_wait_left_next   = ping_wait_left;
    start_next            = 1'b0;
    valid_next            = 1'b0;
    present_next          = 1'b0;

    case (mode)
      MODE_TICK: begin
        if (ping_wait_left != '0) begin
          ping_wait_left_next = ping_wait_left - COUNT_BITS'(1);
        end
        if (debounce_armed && debounce_left != '0) begin
          debounce_left_next = debounce_left - COUNT_BITS'(1);
        end
      end
      MODE_ECHO: begin
        if (pinging && !echo_level) begin
          echo_latch_next = 1'b1;
        end
      end
      MODE_BURST_END: begin
        if (pinging) begin
          pinging_next     = 1'b0;
          raw_present_next = echo_latch;
        end
      end
      default: begin
      end
    endcase

    if (!pinging_next && ping_wait_left_next == '0) begin
      ping_wait_left_next = load_count(ping_interval_ticks);
      echo_latch_next     = 1'b0;
      pinging_next        = 1'b1;
      start_next          = 1'b1;
    end

    if (raw_present_next != last_raw_present) begin
      debounce_left_next    = load_count(debounce_ticks);
      debounce_armed_next   = 1'b1;
      last_raw_present_next = raw_present_next;
    end

    if (debounce_armed_next && debounce_left_next == '0) begin
      valid_next          = 1'b1;
      present_next        = raw_present_next;
      debounce_armed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ping_interval_ticks <= PING_INTERVAL_RESET;
      debounce_ticks      <= DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PING_INTERVAL) begin
        ping_interval_ticks <= cfg_data;
      end else if (cfg_index == REG_DEBOUNCE) begin
        debounce_ticks <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pinging          <= 1'b0;
      echo_latch       <= 1'b0;
      raw_present      <= 1'b0;
      last_raw_present <= 1'b0;
      debounce_armed   <= 1'b0;
      debounce_left    <= '0;
      ping_wait_left   <= '0;
    end else if (in_fire) begin
      pinging          <= pinging_next;
      echo_latch       <= echo_latch_next;
      raw_present      <= raw_present_next;
      last_raw_present <= last_raw_present_next;
      debounce_armed   <= debounce_armed_next;
      debounce_left    <= debounce_left_next;
      ping_wait_left   <= ping_wait_left_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ping_start    <= start_next;
      ping_active   <= pinging_next;
      event_valid   <= valid_next;
      event_present <= present_next;
    end
  end

  a_start_opens_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && ping_start |-> ping_active)
    else $error("ping_start without an open ping window");

  a_present_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_present |-> event_valid)
    else $error("event_present without event_valid");

  a_start_reloads_wait: assert property (@(posedge clk) disable iff (rst)
    in_fire && start_next |=> ping_wait_left == load_count($past(ping_interval_ticks)))
    else $error("ping start did not reload the interval countdown");

  a_change_tracked: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> last_raw_present == raw_present)
    else $error("raw detection change not tracked");

  a_beat_produces_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pulsed_echo_presence_debouncer. A class tracks the
// ping, echo latch and debounce state, predicts one result beat per input
// beat and checks the result stream in order. Directed beats cover reset
// values, zero and full-scale registers, ignored events and the unused mode;
// random phases run well-formed ping cycles under several register settings
// with random idle bursts, a long output hold-off and a final idle-free run.
// ----------------------------------------------------------------------------
module testbench;
  import pedb_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_NONE = MODE_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_INDEX = '1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic ping_start;
    logic ping_active;
    logic event_valid;
    logic event_present;
  } echo_result_t;

  class presence_tracker;
    reg_t interval_reg;
    reg_t debounce_reg;
    bit pinging;
    bit echo_seen;
    bit raw_seen;
    bit prev_raw;
    bit db_armed;
    count_t db_left;
    count_t wait_left;
    echo_result_t pending_results[$];
    int errors;
    int n_checked;
    int n_pings;
    int n_reports;
    int n_present;

    function new();
      interval_reg = PING_INTERVAL_RESET;
      debounce_reg = DEBOUNCE_RESET;
      pinging = 0;
      echo_seen = 0;
      raw_seen = 0;
      prev_raw = 0;
      db_armed = 0;
      db_left = '0;
      wait_left = '0;
      errors = 0;
      n_checked = 0;
      n_pings = 0;
      n_reports = 0;
      n_present = 0;
    endfunction

    function count_t clamp_load(reg_t v);
      longint unsigned top;
      top = (64'd1 << COUNT_BITS) - 64'd1;
      if (64'(v) > top) return '1;
      return count_t'(v);
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, reg_t val);
      if (idx == REG_PING_INTERVAL) interval_reg = val;
      else if (idx == REG_DEBOUNCE) debounce_reg = val;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void take_event(logic [MODE_BITS-1:0] m, logic lvl);
      echo_result_t r;
      r = '0;
      case (m)
        MODE_TICK: begin
          if (wait_left != 0) wait_left = wait_left - 1'b1;
          if (db_armed && db_left != 0) db_left = db_left - 1'b1;
        end
        MODE_ECHO: begin
          if (pinging && !lvl) echo_seen = 1;
        end
        MODE_BURST_END: begin
          if (pinging) begin
            pinging = 0;
            raw_seen = echo_seen;
          end
        end
        default: ;
      endcase
      if (!pinging && wait_left == 0) begin
        wait_left = clamp_load(interval_reg);
        echo_seen = 0;
        pinging = 1;
        r.ping_start = 1'b1;
        n_pings++;
      end
      if (raw_seen != prev_raw) begin
        db_left = clamp_load(debounce_reg);
        db_armed = 1;
        prev_raw = raw_seen;
      end
      if (db_armed && db_left == 0) begin
        r.event_valid = 1'b1;
        r.event_present = raw_seen;
        db_armed = 0;
        n_reports++;
        if (raw_seen) n_present++;
      end
      r.ping_active = pinging;
      pending_results.push_back(r);
    endfunction

    function void match_result(echo_result_t act);
      echo_result_t exp;
      string names[4];
      names = '{"ping_start", "ping_active", "event_valid", "event_present"};
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %b", $time, act);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      n_checked++;
      for (int i = 0; i < 4; i++) begin
        if (act[3-i] !== exp[3-i]) begin
          $display("%0t: %s mismatch, expected %b, actual %b", $time, names[i],
                   exp[3-i], act[3-i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_BITS-1:0] mode = MODE_TICK;
  logic echo_level = 1'b1;
  logic out_valid;
  logic out_ready = 1'b1;
  logic ping_start;
  logic ping_active;
  logic event_valid;
  logic event_present;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  reg_t cfg_data = '0;

  presence_tracker tracker = new();
  int beats_sent = 0;
  int phases_run = 0;
  int stall_count = 0;
  int out_stall_left = 0;
  bit quiet = 0;
  bit hold_req = 0;

  pulsed_echo_presence_debouncer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .echo_level(echo_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ping_start(ping_start),
    .ping_active(ping_active),
    .event_valid(event_valid),
    .event_present(event_present),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_ready = 1'b0;
      out_stall_left--;
    end else if (hold_req) begin
      hold_req = 0;
      out_ready = 1'b0;
      out_stall_left = HOLD_CYCLES - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      out_stall_left = $urandom_range(0, 3);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        tracker.match_result({ping_start, ping_active, event_valid, event_present});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_count = 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_count++;
      end
    end
  end

  task automatic send_beat(logic [MODE_BITS-1:0] m, logic lvl);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = m;
    echo_level = lvl;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_event(m, lvl);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, reg_t val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(reg_t interval, reg_t debounce);
    drain();
    write_reg(REG_PING_INTERVAL, interval);
    write_reg(REG_DEBOUNCE, debounce);
    phases_run++;
  endtask

  // ticks until a window opens, echoes biased by the wanted presence, burst end, trailing ticks
  task automatic ping_cycle(bit want, int cap);
    int k;
    int n;
    n = 0;
    while (!tracker.pinging && n < cap) begin
      send_beat(($urandom_range(0, 9) == 0) ? MODE_ECHO : MODE_TICK,
                1'($urandom_range(0, 1)));
      n++;
    end
    k = $urandom_range(0, 4);
    repeat (k) begin
      send_beat(MODE_ECHO, want ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 3) != 0));
    end
    send_beat(MODE_BURST_END, 1'($urandom_range(0, 1)));
    k = $urandom_range(0, 3);
    repeat (k) send_beat(MODE_TICK, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(reg_t interval, reg_t debounce, int count, bit hold);
    int target;
    int cap;
    bit want;
    set_regs(interval, debounce);
    target = beats_sent + count;
    cap = (int'(interval) + 4 > 130) ? 130 : int'(interval) + 4;
    want = $urandom_range(0, 1);
    if (hold) hold_req = 1;
    while (beats_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 3) == 0) want = !want;
        ping_cycle(want, cap);
      end else begin
        send_beat(MODE_BITS'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values: first beat opens a ping, events outside a window ignored
    send_beat(MODE_TICK, 1'b1);
    send_beat(MODE_ECHO, 1'b0);
    send_beat(MODE_ECHO, 1'b1);
    send_beat(MODE_BURST_END, 1'b0);
    send_beat(MODE_ECHO, 1'b0);
    send_beat(MODE_BURST_END, 1'b1);
    send_beat(MODE_NONE, 1'b0);
    send_beat(MODE_NONE, 1'b1);
    send_beat(MODE_TICK, 1'b0);

    // zero registers, plus writes to unused indexes
    drain();
    write_reg(REG_UNUSED, 16'h1234);
    write_reg(REG_TOP_INDEX, '1);
    set_regs('0, '0);
    send_beat(MODE_ECHO, 1'b0);
    send_beat(MODE_BURST_END, 1'b0);
    send_beat(MODE_ECHO, 1'b1);
    send_beat(MODE_BURST_END, 1'b1);
    send_beat(MODE_NONE, 1'b0);

    // full-scale interval, one-tick debounce
    set_regs('1, reg_t'(1));
    send_beat(MODE_ECHO, 1'b0);
    send_beat(MODE_BURST_END, 1'b0);
    send_beat(MODE_ECHO, 1'b1);
    send_beat(MODE_BURST_END, 1'b1);
    send_beat(MODE_ECHO, 1'b0);
    send_beat(MODE_BURST_END, 1'b0);
    send_beat(MODE_TICK, 1'b1);
    send_beat(MODE_TICK, 1'b0);
    send_beat(MODE_NONE, 1'b1);

    run_phase(PING_INTERVAL_RESET, DEBOUNCE_RESET, 400, 0);
    run_phase(reg_t'(3), reg_t'(5), 300, 1);
    run_phase(reg_t'(1), reg_t'(1), 200, 0);
    run_phase('0, '0, 150, 0);
    run_phase(reg_t'($urandom_range(1, 10)), reg_t'($urandom_range(0, 30)), 300, 0);
    run_phase(reg_t'(2), '0, 120, 0);
    run_phase('1, '1, 60, 0);
    quiet = 1;
    run_phase(reg_t'($urandom_range(1, 6)), reg_t'($urandom_range(1, 12)), 400, 0);

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d input beats over %0d register settings, %0d result beats checked.",
             beats_sent, phases_run, tracker.n_checked);
    $display("Predicted %0d ping starts and %0d debounced reports (%0d present).",
             tracker.n_pings, tracker.n_reports, tracker.n_present);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
